// ===== rtl/jdcc_pkg.sv =====
// Shared constants and tables for the Julian day and calendar date converter.
package jdcc_pkg;

    // Operation codes carried on s_op
    localparam logic OP_TO_JULIAN   = 1'b0;
    localparam logic OP_TO_CALENDAR = 1'b1;

    // Calendar reform thresholds (15 Oct 1582)
    localparam logic signed [25:0] GREG_START_KEY = 26'sd588829;
    localparam logic [22:0]        GREG_START_JD  = 23'd2299161;

    // Day number and year offsets, and the output year limit
    localparam logic signed [27:0] JD_BASE_OFS = 28'sd1720995;
    localparam logic [22:0]        ALPHA_OFS   = 23'd1867216;
    localparam logic [23:0]        B_OFS       = 24'd1524;
    localparam logic [27:0]        C_NUM_OFS   = 28'd2442;
    localparam logic signed [15:0] YEAR_OFS    = 16'sd4715;
    localparam logic signed [15:0] YEAR_MAX    = 16'sd16383;

    // Reciprocal of 100 for the century count, exact for magnitudes below 2**15
    localparam int            CENT_SHIFT = 19;
    localparam logic [63:0]   CENT_MUL64 = ((64'd1 << CENT_SHIFT) + 64'd99) / 64'd100;
    localparam logic [12:0]   CENT_MUL   = CENT_MUL64[12:0];

    // Reciprocal of 146097 for alpha, exact for numerators below 2**25
    localparam int            ALPHA_SHIFT = 43;
    localparam logic [63:0]   ALPHA_MUL64 = ((64'd1 << ALPHA_SHIFT) + 64'd146096) / 64'd146097;
    localparam logic [25:0]   ALPHA_MUL   = ALPHA_MUL64[25:0];

    // Reciprocal of 7305 for the year count, exact for numerators below 2**28
    localparam int            YCNT_SHIFT = 41;
    localparam logic [63:0]   YCNT_MUL64 = ((64'd1 << YCNT_SHIFT) + 64'd7304) / 64'd7305;
    localparam logic [28:0]   YCNT_MUL   = YCNT_MUL64[28:0];

    // Scaled reciprocal of 30.6001 for the month count, exact for 9-bit inputs
    localparam int            MCNT_SHIFT = 28;
    localparam logic [63:0]   MCNT_MUL64 =
        ((64'd1 << MCNT_SHIFT) * 64'd10000 + 64'd306000) / 64'd306001;
    localparam logic [23:0]   MCNT_MUL   = MCNT_MUL64[23:0];

    // floor(30.6001 * j) for the month index j
    function automatic logic [8:0] month_ofs(input logic [4:0] j);
        logic [8:0] r;
        case (j)
            5'd1:    r = 9'd30;
            5'd2:    r = 9'd61;
            5'd3:    r = 9'd91;
            5'd4:    r = 9'd122;
            5'd5:    r = 9'd153;
            5'd6:    r = 9'd183;
            5'd7:    r = 9'd214;
            5'd8:    r = 9'd244;
            5'd9:    r = 9'd275;
            5'd10:   r = 9'd306;
            5'd11:   r = 9'd336;
            5'd12:   r = 9'd367;
            5'd13:   r = 9'd397;
            5'd14:   r = 9'd428;
            5'd15:   r = 9'd459;
            5'd16:   r = 9'd489;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/julian_day_calendar_converter.sv =====
// Pipelined converter between calendar dates and Julian day numbers.
//
// Each transfer on the s_ channel carries one request: s_op selects date to day
// number or day number to date, and exactly one result transfer follows on the
// m_ channel, in order. The pipeline has seven register stages, and a new
// request can be taken every cycle unless all stages are full behind a stalled
// result. The depth is set by the three constant divisions of the reverse
// direction (by 146097, by 7305 and by 30.6001), each done as a multiplication
// by a scaled reciprocal with its own stage. Each stage holds its item when the
// stage after it is full and holding, so the block keeps taking requests into
// empty stages while a result waits on m_ready. Dates before 15 Oct 1582
// use the Julian calendar, later ones the Gregorian; negative years are BC.
module julian_day_calendar_converter import jdcc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_op,
    input  logic [3:0]         s_in_month,
    input  logic [7:0]         s_in_day,
    input  logic signed [14:0] s_in_year,
    input  logic [22:0]        s_in_julian_day,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [22:0]        m_out_julian_day,
    output logic [3:0]         m_out_month,
    output logic [4:0]         m_out_day,
    output logic signed [14:0] m_out_year,
    output logic               m_invalid
);

    // ---------------------------------------------------------------- control
    logic [6:1] v_reg;
    logic       m_valid_reg;
    logic [7:1] ld;

    // Let a stage load when it is empty or its item moves on
    always_comb begin
        ld[7] = !m_valid_reg || m_ready;
        for (int k = 6; k >= 1; k--) begin
            ld[k] = !v_reg[k] || ld[k+1];
        end
    end

    assign s_ready = ld[1];
    assign m_valid = m_valid_reg;

    // Advance valid bits with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (ld[1]) v_reg[1] <= s_valid;
            for (int k = 2; k <= 6; k++) begin
                if (ld[k]) v_reg[k] <= v_reg[k-1];
            end
            if (ld[7]) m_valid_reg <= v_reg[6];
        end
    end

    // ---------------------------------------------------------------- stage 1
    logic signed [15:0] yr_ext, yadj, jy_next;
    logic               mon_gt2;
    logic [4:0]         jm_next;
    logic signed [25:0] mix, key;
    logic signed [27:0] p1461_next;
    logic [14:0]        jy_abs_next;
    logic [22:0]        jofs;
    logic [24:0]        an_next;

    // Prepare the year/month split and the reform tests
    always_comb begin
        yr_ext      = {s_in_year[14], s_in_year};
        yadj        = (yr_ext < 16'sd0) ? yr_ext + 16'sd1 : yr_ext;
        mon_gt2     = s_in_month > 4'd2;
        jy_next     = mon_gt2 ? yadj : yadj - 16'sd1;
        jm_next     = mon_gt2 ? {1'b0, s_in_month} + 5'd1 : {1'b0, s_in_month} + 5'd13;
        mix         = $signed({{10{yadj[15]}}, yadj}) * 26'sd12
                      + $signed({22'd0, s_in_month});
        key         = mix * 26'sd31 + $signed({18'd0, s_in_day});
        p1461_next  = $signed({{12{jy_next[15]}}, jy_next}) * 28'sd1461;
        jy_abs_next = jy_next[15] ? 15'(-jy_next) : jy_next[14:0];
        jofs        = s_in_julian_day - ALPHA_OFS;
        an_next     = {jofs, 2'b00} - 25'd1;
    end

    logic               op1_reg, jz1_reg, jneg1_reg, gj1_reg, gc1_reg;
    logic [7:0]         day1_reg;
    logic [22:0]        jdn1_reg;
    logic [14:0]        jabs1_reg;
    logic [4:0]         jm1_reg;
    logic signed [27:0] p1461_reg;
    logic [24:0]        an1_reg;

    // ---------------------------------------------------------------- stage 2
    logic signed [27:0] q1461, base_next;
    logic [27:0]        cprod;
    logic [50:0]        aprod;

    // Sum the day number parts; scale for century and alpha quotients
    always_comb begin
        q1461     = p1461_reg >>> 2;
        base_next = q1461 + $signed({19'd0, month_ofs(jm1_reg)})
                    + $signed({20'd0, day1_reg}) + JD_BASE_OFS;
        cprod     = {13'd0, jabs1_reg} * {15'd0, CENT_MUL};
        aprod     = {26'd0, an1_reg} * {25'd0, ALPHA_MUL};
    end

    logic               op2_reg, jz2_reg, jneg2_reg, gj2_reg, gc2_reg;
    logic [22:0]        jdn2_reg;
    logic signed [27:0] base2_reg;
    logic [8:0]         cq2_reg;
    logic [7:0]         alpha2_reg;

    // ---------------------------------------------------------------- stage 3
    logic signed [10:0] cent_u, c4_u, cent, c4, corr;
    logic signed [27:0] jd_full;
    logic [22:0]        jd_next;
    logic [23:0]        a_val, b_next;
    logic [27:0]        cnum_next;

    // Apply the Gregorian correction and clamp negative day numbers to zero; form the year count numerator
    always_comb begin
        cent_u  = $signed({2'b00, cq2_reg});
        c4_u    = $signed({4'b0000, cq2_reg[8:2]});
        cent    = jneg2_reg ? -cent_u : cent_u;
        c4      = jneg2_reg ? -c4_u : c4_u;
        corr    = 11'sd2 - cent + c4;
        jd_full = base2_reg + (gj2_reg ? $signed({{17{corr[10]}}, corr}) : 28'sd0);
        jd_next = (jd_full < 28'sd0) ? 23'd0 : jd_full[22:0];
        a_val   = gc2_reg ? {1'b0, jdn2_reg} + 24'd1 + {16'd0, alpha2_reg}
                            - {18'd0, alpha2_reg[7:2]}
                          : {1'b0, jdn2_reg};
        b_next    = a_val + B_OFS;
        cnum_next = {4'd0, b_next} * 28'd20 - C_NUM_OFS;
    end

    logic        op3_reg, jz3_reg;
    logic [22:0] jd3_reg;
    logic [23:0] b3_reg;
    logic [27:0] cnum3_reg;

    // ---------------------------------------------------------------- stage 4
    logic [56:0] yprod;

    // Divide by 7305
    assign yprod = {29'd0, cnum3_reg} * {28'd0, YCNT_MUL};

    logic        op4_reg, jz4_reg;
    logic [22:0] jd4_reg;
    logic [23:0] b4_reg;
    logic [14:0] c4_reg;

    // ---------------------------------------------------------------- stage 5
    logic [23:0] dcnt, rem;

    // Take the whole days of the counted years off
    always_comb begin
        dcnt = {9'd0, c4_reg} * 24'd365 + {11'd0, c4_reg[14:2]};
        rem  = b4_reg - dcnt;
    end

    logic        op5_reg, jz5_reg;
    logic [22:0] jd5_reg;
    logic [14:0] c5_reg;
    logic [8:0]  n5_reg;

    // ---------------------------------------------------------------- stage 6
    logic [32:0] mprod;

    // Divide the day remainder by 30.6001
    assign mprod = {24'd0, n5_reg} * {9'd0, MCNT_MUL};

    logic        op6_reg, jz6_reg;
    logic [22:0] jd6_reg;
    logic [14:0] c6_reg;
    logic [8:0]  n6_reg;
    logic [3:0]  e6_reg;

    // ---------------------------------------------------------------- output
    logic [8:0]         dfull;
    logic [3:0]         mon0, mon_next;
    logic signed [15:0] y0, y1, y2, y_next;
    logic [22:0]        ojd_next;
    logic [3:0]         omon_next;
    logic [4:0]         oday_next;
    logic signed [14:0] oyear_next;
    logic               oinv_next;

    // Finish the calendar date and select the result by operation
    always_comb begin
        dfull    = n6_reg - month_ofs({1'b0, e6_reg});
        mon0     = e6_reg - 4'd1;
        mon_next = (mon0 > 4'd12) ? mon0 - 4'd12 : mon0;
        y0       = $signed({1'b0, c6_reg}) - YEAR_OFS;
        y1       = (mon_next > 4'd2) ? y0 - 16'sd1 : y0;
        y2       = (y1 <= 16'sd0) ? y1 - 16'sd1 : y1;
        y_next   = (y2 > YEAR_MAX) ? YEAR_MAX : y2;

        ojd_next   = '0;
        omon_next  = '0;
        oday_next  = '0;
        oyear_next = '0;
        oinv_next  = 1'b0;
        if (op6_reg == OP_TO_JULIAN) begin
            ojd_next = jd6_reg;
        end else if (jz6_reg) begin
            oinv_next = 1'b1;
        end else begin
            omon_next  = mon_next;
            oday_next  = dfull[4:0];
            oyear_next = y_next[14:0];
        end
    end

    logic [22:0]        ojd_reg;
    logic [3:0]         omon_reg;
    logic [4:0]         oday_reg;
    logic signed [14:0] oyear_reg;
    logic               oinv_reg;

    // Move payload down the pipeline; each stage holds while stalled
    always_ff @(posedge aclk) begin
        if (ld[1]) begin
            op1_reg   <= s_op;
            jz1_reg   <= (s_in_julian_day == 23'd0);
            jneg1_reg <= jy_next[15];
            gj1_reg   <= (key >= GREG_START_KEY);
            gc1_reg   <= (s_in_julian_day >= GREG_START_JD);
            day1_reg  <= s_in_day;
            jdn1_reg  <= s_in_julian_day;
            jabs1_reg <= jy_abs_next;
            jm1_reg   <= jm_next;
            p1461_reg <= p1461_next;
            an1_reg   <= an_next;
        end
        if (ld[2]) begin
            op2_reg    <= op1_reg;
            jz2_reg    <= jz1_reg;
            jneg2_reg  <= jneg1_reg;
            gj2_reg    <= gj1_reg;
            gc2_reg    <= gc1_reg;
            jdn2_reg   <= jdn1_reg;
            base2_reg  <= base_next;
            cq2_reg    <= cprod[27:CENT_SHIFT];
            alpha2_reg <= aprod[50:ALPHA_SHIFT];
        end
        if (ld[3]) begin
            op3_reg   <= op2_reg;
            jz3_reg   <= jz2_reg;
            jd3_reg   <= jd_next;
            b3_reg    <= b_next;
            cnum3_reg <= cnum_next;
        end
        if (ld[4]) begin
            op4_reg <= op3_reg;
            jz4_reg <= jz3_reg;
            jd4_reg <= jd3_reg;
            b4_reg  <= b3_reg;
            c4_reg  <= yprod[55:YCNT_SHIFT];
        end
        if (ld[5]) begin
            op5_reg <= op4_reg;
            jz5_reg <= jz4_reg;
            jd5_reg <= jd4_reg;
            c5_reg  <= c4_reg;
            n5_reg  <= rem[8:0];
        end
        if (ld[6]) begin
            op6_reg <= op5_reg;
            jz6_reg <= jz5_reg;
            jd6_reg <= jd5_reg;
            c6_reg  <= c5_reg;
            n6_reg  <= n5_reg;
            e6_reg  <= mprod[31:MCNT_SHIFT];
        end
        if (ld[7]) begin
            ojd_reg   <= ojd_next;
            omon_reg  <= omon_next;
            oday_reg  <= oday_next;
            oyear_reg <= oyear_next;
            oinv_reg  <= oinv_next;
        end
    end

    assign m_out_julian_day = ojd_reg;
    assign m_out_month      = omon_reg;
    assign m_out_day        = oday_reg;
    assign m_out_year       = oyear_reg;
    assign m_invalid        = oinv_reg;

    // ---------------------------------------------------------------- checks
    // A full pipeline behind a stalled result must refuse new requests
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (&v_reg) && m_valid_reg && !m_ready |-> !s_ready)
        else $error("request taken while pipeline is full and stalled");

    // A taken request occupies the first stage next cycle
    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> v_reg[1])
        else $error("taken request lost at pipeline entry");

    // An invalid flag comes with an all-zero date and day number
    a_inv_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_invalid |-> (m_out_julian_day == 23'd0) && (m_out_month == 4'd0)
                                 && (m_out_day == 5'd0) && (m_out_year == 15'sd0))
        else $error("invalid result carries nonzero fields");

    // A calendar result is a real date with a nonzero year
    a_cal_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_out_month != 4'd0) |-> (m_out_month <= 4'd12) && (m_out_day != 5'd0)
                                             && (m_out_year != 15'sd0)
                                             && (m_out_julian_day == 23'd0))
        else $error("calendar result out of range");

endmodule

// ===== tb/julian_day_calendar_converter_test.sv =====
// Self-checking testbench for the Julian day / calendar date converter.
module julian_day_calendar_converter_test import jdcc_pkg::*; ();

    // Calendar reform limits: first Gregorian day number and the matching
    // day + 31 * (month + 12 * year) key for op 0
    localparam int REFORM_DAY_NUMBER = 2299161;
    localparam int REFORM_DATE_KEY   = 588829;
    localparam int LAST_DAY_9999     = 5373484;
    localparam int MAX_DAY_NUMBER    = 8388607;
    localparam int MAX_OUT_YEAR      = 16383;
    localparam int MIN_OUT_YEAR      = -16384;
    localparam int MAX_PRINTED       = 40;
    localparam int DRAIN_CYCLES      = 20;

    typedef struct packed {
        logic               op;
        logic [3:0]         month;
        logic [7:0]         day;
        logic signed [14:0] year;
        logic [22:0]        jd;
    } date_req_t;

    typedef struct packed {
        logic [22:0]        jd;
        logic [3:0]         month;
        logic [4:0]         day;
        logic signed [14:0] year;
        logic               invalid;
    } date_rsp_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic               s_op;
    logic [3:0]         s_in_month;
    logic [7:0]         s_in_day;
    logic signed [14:0] s_in_year;
    logic [22:0]        s_in_julian_day;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [22:0]        m_out_julian_day;
    logic [3:0]         m_out_month;
    logic [4:0]         m_out_day;
    logic signed [14:0] m_out_year;
    logic               m_invalid;

    date_rsp_t expected_conversions[$];
    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;
    int        mismatch_count = 0;
    int        result_count   = 0;

    julian_day_calendar_converter i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_op             (s_op),
        .s_in_month       (s_in_month),
        .s_in_day         (s_in_day),
        .s_in_year        (s_in_year),
        .s_in_julian_day  (s_in_julian_day),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_julian_day (m_out_julian_day),
        .m_out_month      (m_out_month),
        .m_out_day        (m_out_day),
        .m_out_year       (m_out_year),
        .m_invalid        (m_invalid)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Compute the converted date or day number for one request
    function automatic date_rsp_t predict_conversion(input date_req_t req);
        date_rsp_t r;
        int mon, dd, yr, jy, jm, jd, cent, prod;
        int jdn, alpha, a, b, c, d, n, e;
        r = '0;
        if (req.op == OP_TO_JULIAN) begin
            mon = int'(req.month);
            dd  = int'(req.day);
            yr  = int'($signed(req.year));
            // no year zero: shift BC years up by one
            if (yr < 0) yr++;
            if (mon > 2) begin
                jy = yr;
                jm = mon + 1;
            end else begin
                jy = yr - 1;
                jm = mon + 13;
            end
            // floor of 365.25 * jy, also for negative jy
            prod = 1461 * jy;
            jd = (prod >= 0) ? prod / 4 : -((-prod + 3) / 4);
            jd += (306001 * jm) / 10000 + dd + 1720995;
            // apply the Gregorian correction from the reform on
            if (dd + 31 * (mon + 12 * yr) >= REFORM_DATE_KEY) begin
                cent = jy / 100;
                jd += 2 - cent + cent / 4;
            end
            if (jd < 0) jd = 0;
            r.jd = jd[22:0];
        end else if (req.jd == '0) begin
            r.invalid = 1'b1;
        end else begin
            jdn = int'(req.jd);
            if (jdn >= REFORM_DAY_NUMBER) begin
                alpha = (4 * (jdn - 1867216) - 1) / 146097;
                a = jdn + 1 + alpha - alpha / 4;
            end else begin
                a = jdn;
            end
            b = a + 1524;
            c = (20 * b - 2442) / 7305;
            d = 365 * c + c / 4;
            n = b - d;
            e = (n >= 0) ? (10000 * n) / 306001 : -((10000 * -n) / 306001);
            dd  = n - (306001 * e) / 10000;
            mon = e - 1;
            if (mon > 12) mon -= 12;
            yr = c - 4715;
            if (mon > 2) yr--;
            if (yr <= 0) yr--;
            // clamp to the output year range
            if (yr > MAX_OUT_YEAR) yr = MAX_OUT_YEAR;
            if (yr < MIN_OUT_YEAR) yr = MIN_OUT_YEAR;
            r.month = mon[3:0];
            r.day   = dd[4:0];
            r.year  = yr[14:0];
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        // keep the log short on a badly broken block, but count everything
        if (mismatch_count < MAX_PRINTED) $display("ERROR at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // Drive one request and hold it until the transfer
    task automatic send_item(input date_req_t req);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_op            <= req.op;
        s_in_month      <= req.month;
        s_in_day        <= req.day;
        s_in_year       <= req.year;
        s_in_julian_day <= req.jd;
        expected_conversions.push_back(predict_conversion(req));
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    function automatic date_req_t make_date(input int month, input int day, input int year);
        date_req_t req;
        req       = '0;
        req.op    = OP_TO_JULIAN;
        req.month = 4'(month);
        req.day   = 8'(day);
        req.year  = 15'(year);
        return req;
    endfunction

    function automatic date_req_t make_day_number(input int jd);
        date_req_t req;
        req    = '0;
        req.op = OP_TO_CALENDAR;
        req.jd = 23'(jd);
        return req;
    endfunction

    // Mostly dates with fields in range, sometimes any bit pattern
    function automatic date_req_t pick_date();
        date_req_t req;
        int        year;
        if ($urandom_range(9) < 8) begin
            year = int'($urandom_range(14712)) - 4713;
            req  = make_date($urandom_range(12, 1), $urandom_range(31, 1), year);
        end else begin
            req = make_date($urandom_range(15), $urandom_range(255), int'($urandom));
        end
        // unused field carries noise
        req.jd = 23'($urandom);
        return req;
    endfunction

    task automatic test_reform_boundary();
        send_item(make_date(10, 4, 1582));
        send_item(make_date(10, 5, 1582));
        send_item(make_date(10, 14, 1582));
        send_item(make_date(10, 15, 1582));
        send_item(make_day_number(REFORM_DAY_NUMBER - 1));
        send_item(make_day_number(REFORM_DAY_NUMBER));
    endtask

    task automatic test_field_extremes();
        send_item(make_date(1, 1, -4713));
        send_item(make_date(1, 1, 2000));
        // months outside 1..12 pass through unchecked
        send_item(make_date(0, 1, 2000));
        send_item(make_date(13, 1, 2000));
        send_item(make_date(15, 255, 2000));
        send_item(make_date(12, 0, 2000));
        // year zero acts as 1 BC
        send_item(make_date(3, 1, 0));
        send_item(make_date(3, 1, -1));
        send_item(make_date(12, 31, MAX_OUT_YEAR));
        // far BC year clamps the day number to zero
        send_item(make_date(1, 1, MIN_OUT_YEAR));
        send_item(make_date(2, 29, 1900));
        send_item(make_day_number(0));
        send_item(make_day_number(1));
        send_item(make_day_number(2451545));
        send_item(make_day_number(LAST_DAY_9999));
        send_item(make_day_number(4194304));
        // far future day number clamps the year
        send_item(make_day_number(MAX_DAY_NUMBER));
    endtask

    task automatic test_random_dates(input int count);
        repeat (count) send_item(pick_date());
    endtask

    task automatic test_random_day_numbers(input int count);
        date_req_t req;
        int        pick;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 5)
                req = make_day_number(0);
            else if (pick < 20)
                req = make_day_number(int'($urandom_range(MAX_DAY_NUMBER)));
            else if (pick < 35)
                req = make_day_number(REFORM_DAY_NUMBER - 400 + int'($urandom_range(800)));
            else
                req = make_day_number(int'($urandom_range(LAST_DAY_9999, 1)));
            // unused fields carry noise
            req.month = 4'($urandom);
            req.day   = 8'($urandom);
            req.year  = 15'($urandom);
            send_item(req);
        end
    endtask

    // Convert a date, then convert the resulting day number back
    task automatic test_round_trip(input int pairs);
        date_req_t req;
        date_rsp_t rsp;
        repeat (pairs) begin
            req = pick_date();
            send_item(req);
            rsp = predict_conversion(req);
            send_item(make_day_number(int'(rsp.jd)));
        end
    endtask

    // Compare a taken result with the oldest expectation
    task automatic check_result();
        date_rsp_t want;
        if (expected_conversions.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with none expected", result_count));
        end else begin
            want = expected_conversions.pop_front();
            if (m_out_julian_day !== want.jd)
                report_mismatch($sformatf("result %0d day number got %0d expected %0d",
                    result_count, m_out_julian_day, want.jd));
            if (m_out_month !== want.month)
                report_mismatch($sformatf("result %0d month got %0d expected %0d",
                    result_count, m_out_month, want.month));
            if (m_out_day !== want.day)
                report_mismatch($sformatf("result %0d day got %0d expected %0d",
                    result_count, m_out_day, want.day));
            if (m_out_year !== want.year)
                report_mismatch($sformatf("result %0d year got %0d expected %0d",
                    result_count, m_out_year, want.year));
            if (m_invalid !== want.invalid)
                report_mismatch($sformatf("result %0d invalid got %0b expected %0b",
                    result_count, m_invalid, want.invalid));
        end
        result_count++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) check_result();
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        aresetn         <= 1'b0;
        s_valid         <= 1'b0;
        s_op            <= OP_TO_JULIAN;
        s_in_month      <= '0;
        s_in_day        <= '0;
        s_in_year       <= '0;
        s_in_julian_day <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_idling(0, 0);
        test_reform_boundary();
        test_field_extremes();
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: set_idling(0, 0);
                1: set_idling(50, 0);
                2: set_idling(0, 50);
                default: set_idling(22, 22);
            endcase
            test_random_dates(130);
            test_random_day_numbers(130);
            test_round_trip(60);
        end

        // drop valid and wait for the pipeline to empty
        s_valid <= 1'b0;
        while (expected_conversions.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Stop a hung run
    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
